>>> design/vakf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vakf_pkg: shared types and helpers for the velocity/accel Kalman filter
// Micro-operation codes, register indexes, command/status structs, saturation.
// ----------------------------------------------------------------------------
package vakf_pkg;

  localparam int unsigned DivSteps = 48;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);

  typedef enum logic [2:0] {
    REG_Q_VELOCITY       = 3'd0,
    REG_Q_ACCEL          = 3'd1,
    REG_R_MEASURE        = 3'd2,
    REG_INITIAL_VELOCITY = 3'd3,
    REG_INITIAL_ACCEL    = 3'd4
  } vakf_reg_e;

  typedef enum logic [3:0] {
    OP_V_PRED,
    OP_T,
    OP_CVA_PRED,
    OP_CAV_PRED,
    OP_CAA_PRED,
    OP_CVV_PRED,
    OP_V_CORR,
    OP_A_CORR,
    OP_CVV_CORR,
    OP_CVA_CORR,
    OP_CAV_CORR,
    OP_CAA_CORR
  } vakf_op_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    logic     wb_en;
    logic     div_start;
    logic     out_load;
    vakf_op_e op;
  } vakf_cmd_t;

  typedef struct packed {
    logic div_done;
  } vakf_status_t;

  function automatic logic signed [49:0] sx50(input logic signed [31:0] x);
    sx50 = {{18{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sh0_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -50'sh0_0000_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

>>> design/vakf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vakf_div: gain divider
// Radix-2 restoring division of (num << 16) by den, one quotient bit a cycle,
// truncated toward zero and saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module vakf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [33:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import vakf_pkg::*;

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [47:0]     dvd_q, dvd_d;
  logic [32:0]     rem_q, rem_d, dmag_q, dmag_d;
  logic            neg_q, neg_d, nz_q, nz_d;
  logic [32:0]     nmag;
  logic [33:0]     dneg, r2, diff;
  logic            ge;

  always_comb begin
    nmag   = num_i[31] ? (33'd0 - {num_i[31], num_i}) : {num_i[31], num_i};
    dneg   = 34'd0 - den_i;
    r2     = {rem_q, dvd_q[47]};
    diff   = r2 - {1'b0, dmag_q};
    ge     = (r2 >= {1'b0, dmag_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    nz_d   = nz_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DivSteps);
      dvd_d  = {nmag[31:0], 16'd0};
      rem_d  = '0;
      dmag_d = den_i[33] ? dneg[32:0] : den_i[32:0];
      neg_d  = num_i[31] ^ den_i[33];
      nz_d   = (num_i == 32'sd0);
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d  = ge ? diff[32:0] : r2[32:0];
      dvd_d  = {dvd_q[46:0], ge};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    nz_q   <= nz_d;
  end

  always_comb begin
    if (nz_q) begin
      quo_o = 32'sd0;
    end else if (!neg_q) begin
      quo_o = (dvd_q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd_q[31:0];
    end else begin
      quo_o = (dvd_q > 48'h8000_0000) ? 32'sh8000_0000 : (32'd0 - dvd_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

>>> design/vakf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vakf_datapath: filter state, shared multiplier and gain dividers
// One registered 32x32 multiply, then a saturating accumulate into the target.
// ----------------------------------------------------------------------------
module vakf_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vakf_pkg::vakf_cmd_t cmd_i,
  output vakf_pkg::vakf_status_t status_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [31:0]  measured_velocity_i,
  input  logic [15:0]         time_step_i,
  output logic signed [31:0]  filtered_velocity_o
);
  import vakf_pkg::*;

  logic [30:0]        qv_q, qa_q, r_q;
  logic signed [31:0] v_q, a_q, cvv_q, cva_q, cav_q, caa_q;
  logic signed [31:0] t_q, kv_q, ka_q, y_q, pvv_q, pva_q, meas_q, out_q;
  logic [15:0]        dt_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] op_a, op_b, dtx, res, kv_w, ka_w;
  logic signed [49:0] term, addend, sum;
  logic               sub;
  logic signed [33:0] den;
  logic               done_kv, done_ka;

  assign dtx = {16'd0, dt_q};
  assign den = {{2{cvv_q[31]}}, cvv_q} + {3'd0, r_q};

  vakf_div u_div_kv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (cvv_q),
    .den_i  (den),
    .done_o (done_kv),
    .quo_o  (kv_w)
  );

  vakf_div u_div_ka (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (cav_q),
    .den_i  (den),
    .done_o (done_ka),
    .quo_o  (ka_w)
  );

  assign status_o.div_done = done_kv & done_ka;

  always_comb begin
    op_a   = dtx;
    op_b   = a_q;
    addend = sx50(v_q);
    sub    = 1'b0;
    case (cmd_i.op)
      OP_V_PRED:   begin op_a = dtx; op_b = a_q;   addend = sx50(v_q); end
      OP_T:        begin
        op_a = dtx; op_b = caa_q;
        addend = sx50(cva_q) + sx50(cav_q) + {19'd0, qv_q};
      end
      OP_CVA_PRED: begin op_a = dtx; op_b = caa_q; addend = sx50(cva_q); end
      OP_CAV_PRED: begin op_a = dtx; op_b = caa_q; addend = sx50(cav_q); end
      OP_CAA_PRED: begin op_a = dtx; op_b = {1'b0, qa_q}; addend = sx50(caa_q); end
      OP_CVV_PRED: begin op_a = dtx; op_b = t_q;   addend = sx50(cvv_q); end
      OP_V_CORR:   begin op_a = kv_q; op_b = y_q;  addend = sx50(v_q); end
      OP_A_CORR:   begin op_a = ka_q; op_b = y_q;  addend = sx50(a_q); end
      OP_CVV_CORR: begin op_a = kv_q; op_b = pvv_q; addend = sx50(cvv_q); sub = 1'b1; end
      OP_CVA_CORR: begin op_a = kv_q; op_b = pva_q; addend = sx50(cva_q); sub = 1'b1; end
      OP_CAV_CORR: begin op_a = ka_q; op_b = pvv_q; addend = sx50(cav_q); sub = 1'b1; end
      OP_CAA_CORR: begin op_a = ka_q; op_b = pva_q; addend = sx50(caa_q); sub = 1'b1; end
      default:     begin op_a = dtx; op_b = a_q; addend = sx50(v_q); end
    endcase
    // floor of product / 2^16
    term = {{2{prod_q[63]}}, prod_q[63:16]};
    sum  = sub ? (addend - term) : (addend + term);
    res  = sat32(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q  <= 31'd3277;
      qa_q  <= 31'd3277;
      r_q   <= 31'd13107;
      v_q   <= '0;
      a_q   <= '0;
      cvv_q <= '0;
      cva_q <= '0;
      cav_q <= '0;
      caa_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_Q_VELOCITY:       qv_q <= cfg_data_i[30:0];
          REG_Q_ACCEL:          qa_q <= cfg_data_i[30:0];
          REG_R_MEASURE:        r_q  <= cfg_data_i[30:0];
          REG_INITIAL_VELOCITY: v_q  <= cfg_data_i;
          REG_INITIAL_ACCEL:    a_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.wb_en) begin
        case (cmd_i.op)
          OP_V_PRED, OP_V_CORR:                   v_q   <= res;
          OP_A_CORR:                              a_q   <= res;
          OP_CVV_PRED, OP_CVV_CORR:               cvv_q <= res;
          OP_CVA_PRED, OP_CVA_CORR:               cva_q <= res;
          OP_CAV_PRED, OP_CAV_CORR:               cav_q <= res;
          OP_CAA_PRED, OP_CAA_CORR:               caa_q <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      meas_q <= measured_velocity_i;
      dt_q   <= time_step_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= op_a * op_b;
    end
    if (cmd_i.wb_en && cmd_i.op == OP_T) begin
      t_q <= res;
    end
    if (cmd_i.div_start) begin
      y_q   <= sat32(sx50(meas_q) - sx50(v_q));
      pvv_q <= cvv_q;
      pva_q <= cva_q;
    end
    if (status_o.div_done) begin
      kv_q <= kv_w;
      ka_q <= ka_w;
    end
    if (cmd_i.out_load) begin
      out_q <= v_q;
    end
  end

  assign filtered_velocity_o = out_q;

endmodule

>>> design/vakf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vakf_ctrl: filter sequencer
// Walk the micro-operations, wait on the dividers, hand off the result word.
// ----------------------------------------------------------------------------
module vakf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  vakf_pkg::vakf_status_t status_i,
  output vakf_pkg::vakf_cmd_t    cmd_o
);
  import vakf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_DIV_START, ST_DIV_WAIT, ST_OUT
  } state_e;

  state_e   state_q;
  vakf_op_e op_q;
  logic     out_valid_q;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.load_in   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_en    = (state_q == ST_MUL);
    cmd_o.wb_en     = (state_q == ST_WB);
    cmd_o.div_start = (state_q == ST_DIV_START);
    cmd_o.out_load  = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_V_PRED;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= OP_V_PRED;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_WB;
        ST_WB: begin
          if (op_q == OP_CVV_PRED) begin
            state_q <= ST_DIV_START;
          end else if (op_q == OP_CAA_CORR) begin
            state_q <= ST_OUT;
          end else begin
            op_q    <= vakf_op_e'(op_q + 4'd1);
            state_q <= ST_MUL;
          end
        end
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (status_i.div_done) begin
            op_q    <= OP_V_CORR;
            state_q <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/velocity_accel_kalman_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_accel_kalman_filter_top: two-state velocity/acceleration Kalman filter
// Takes a velocity measurement and time step, returns the corrected velocity.
// ----------------------------------------------------------------------------
// Each accepted word runs six prediction updates and six correction updates,
// each one pass through the one shared 32x32 multiplier and its saturating
// accumulator, with the two gain divisions between them (a start step, 48
// quotient bits one a cycle, and a done step), which run side by side; then
// the output register is loaded.
// The input stalls while a word is in work; a finished result waits in an
// output register, so the next word may be taken while it is still pending.
// Configuration writes must only arrive while the filter is idle; writing the
// initial velocity or acceleration register also loads that state at once.
// All values are signed Q16.16 with saturation, time_step unsigned Q0.16.
module velocity_accel_kalman_filter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] measured_velocity_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] filtered_velocity_o
);
  import vakf_pkg::*;

  vakf_cmd_t    cmd;
  vakf_status_t status;

  // sequencer: owns the handshakes and the micro-operation order
  vakf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // state, registers, multiplier and dividers
  vakf_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .measured_velocity_i(measured_velocity_i),
    .time_step_i        (time_step_i),
    .filtered_velocity_o(filtered_velocity_o)
  );

endmodule

>>> design/vakf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vakf_checker: port-level checks for the Kalman filter
// Hold of the result word, busy after accept, result present on release.
// ----------------------------------------------------------------------------
module vakf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] filtered_velocity_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_velocity_o))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !$rose(out_valid_o))
    else $error("filter not busy after accepting a word");

  a_result_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("filter went idle without a result");

endmodule

bind velocity_accel_kalman_filter_top vakf_checker u_vakf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .filtered_velocity_o(filtered_velocity_o)
);

>>> bench/velocity_accel_kalman_filter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_accel_kalman_filter_top_test: regression for the Kalman filter top
// Drives measurement words, mirrors the filter arithmetic in a local model
// and checks every filtered velocity word in order, under random idling.
// ----------------------------------------------------------------------------
module velocity_accel_kalman_filter_top_test;
  import vakf_pkg::*;

  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam logic [2:0] IdxLastUsed = REG_INITIAL_ACCEL;
  // Cycles to let a word finish in the filter before a register write.
  localparam int SettleCycles = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] measured_velocity_i;
  logic [15:0]        time_step_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] filtered_velocity_o;

  velocity_accel_kalman_filter_top uut (.*);

  // Local copy of the filter registers and state, all widened to 64 bits.
  longint q_vel, q_acc, r_meas;
  longint vel_est, acc_est, p_vv, p_va, p_av, p_aa;

  logic signed [31:0] velocity_due_q[$];
  int  fail_count;
  bit  quiet;        // no random idling on either side while set
  int  hold_request; // receiver hold-off, taken up by the receiver process
  int  hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("velocity_accel_kalman_filter_top regression: fail");
    $finish;
  end

  function automatic longint clip32(longint x);
    if (x > S32Max) return S32Max;
    if (x < S32Min) return S32Min;
    return x;
  endfunction

  // Exact product, floored by 16 bits.
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint gain_of(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return S32Max;
      if (num < 0) return S32Min;
      return 0;
    end
    return clip32((num * 65536) / den);
  endfunction

  task automatic model_reset();
    q_vel = 3277; q_acc = 3277; r_meas = 13107;
    vel_est = 0; acc_est = 0;
    p_vv = 0; p_va = 0; p_av = 0; p_aa = 0;
  endtask

  function automatic logic signed [31:0] filter_step(logic signed [31:0] meas,
                                                     logic [15:0] step);
    longint m, dt, t, s, kv, ka, y, pvv, pva;
    m  = longint'(meas);
    dt = longint'({48'b0, step});
    vel_est = clip32(vel_est + qmul(dt, acc_est));
    t    = clip32(qmul(dt, p_aa) + p_va + p_av + q_vel);
    p_vv = clip32(p_vv + qmul(dt, t));
    p_va = clip32(p_va + qmul(dt, p_aa));
    p_av = clip32(p_av + qmul(dt, p_aa));
    p_aa = clip32(p_aa + qmul(dt, q_acc));
    s  = p_vv + r_meas;
    kv = gain_of(p_vv, s);
    ka = gain_of(p_av, s);
    y  = clip32(m - vel_est);
    vel_est = clip32(vel_est + qmul(kv, y));
    acc_est = clip32(acc_est + qmul(ka, y));
    pvv = p_vv;
    pva = p_va;
    p_vv = clip32(p_vv - qmul(kv, pvv));
    p_va = clip32(p_va - qmul(kv, pva));
    p_av = clip32(p_av - qmul(ka, pvv));
    p_aa = clip32(p_aa - qmul(ka, pva));
    return vel_est[31:0];
  endfunction

  // Offer one word; hold it until the filter takes it, then queue the result.
  task automatic send_word(logic signed [31:0] meas, logic [15:0] step);
    if (!quiet && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 38);
    end
    in_valid_i          <= 1'b1;
    measured_velocity_i <= meas;
    time_step_i         <= step;
    do @(posedge clk_i); while (in_stall_o);
    velocity_due_q.push_back(filter_step(meas, step));
  endtask

  // Drop valid and wait for every queued result, then let the datapath settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (velocity_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_Q_VELOCITY:       q_vel  = longint'({33'b0, data[30:0]});
      REG_Q_ACCEL:          q_acc  = longint'({33'b0, data[30:0]});
      REG_R_MEASURE:        r_meas = longint'({33'b0, data[30:0]});
      REG_INITIAL_VELOCITY: vel_est = longint'($signed(data));
      REG_INITIAL_ACCEL:    acc_est = longint'($signed(data));
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] rand_meas();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed($urandom_range(2 * 65536 * 50)) - 65536 * 50;
      2:       return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(2 * 65536 * 4)) - 65536 * 4;
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(6554));
      default: return 16'($urandom_range(655, 3277));
    endcase
  endfunction

  // Receiver: check each accepted word, then choose the stall for next cycle.
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (velocity_due_q.size() == 0) begin
          $error("filtered_velocity: no word expected, actual %0d", filtered_velocity_o);
          fail_count++;
        end else begin
          if (filtered_velocity_o !== velocity_due_q[0]) begin
            $error("filtered_velocity: expected %0d, actual %0d",
                   velocity_due_q[0], filtered_velocity_o);
            fail_count++;
          end
          void'(velocity_due_q.pop_front());
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 38);
      end
    end
  end

  // Extremes of both fields straight after reset, default registers.
  task automatic test_field_extremes();
    send_word(32'sh0000_0000, 16'h0000);
    send_word(32'sh7FFF_FFFF, 16'h0000);
    send_word(32'sh8000_0000, 16'hFFFF);
    send_word(32'sh7FFF_FFFF, 16'hFFFF);
    send_word(32'sh0001_0000, 16'h0001);
    send_word(32'shFFFF_FFFF, 16'h8000);
    send_word(32'sh8000_0000, 16'h0000);
    send_word(32'sh0000_0001, 16'hFFFF);
    drain();
  endtask

  // Zero innovation variance: no measurement noise and the covariance not
  // grown, so the gains take their saturated or zero values.
  task automatic test_zero_innovation();
    write_reg(REG_R_MEASURE, 32'h0000_0000);
    write_reg(REG_Q_VELOCITY, 32'h0000_0000);
    write_reg(REG_Q_ACCEL, 32'h0000_0000);
    send_word(32'sh0003_0000, 16'h0000);
    send_word(32'shFFFD_0000, 16'h0000);
    send_word(32'sh0000_0000, 16'h4000);
    send_word(32'sh7FFF_FFFF, 16'h0000);
    drain();
  endtask

  // Every register at its extremes, out-of-range indexes and upper bits.
  task automatic test_registers();
    write_reg(REG_Q_VELOCITY, 32'hFFFF_FFFF);
    write_reg(REG_Q_ACCEL, 32'hFFFF_FFFF);
    write_reg(REG_R_MEASURE, 32'hFFFF_FFFF);
    write_reg(REG_INITIAL_VELOCITY, 32'h7FFF_FFFF);
    write_reg(REG_INITIAL_ACCEL, 32'h8000_0000);
    for (int i = IdxLastUsed + 1; i < 8; i++) write_reg(3'(i), $urandom);
    send_word(32'sh8000_0000, 16'hFFFF);
    send_word(32'sh7FFF_FFFF, 16'hFFFF);
    send_word(32'sh0000_0000, 16'h1000);
    drain();
    write_reg(REG_INITIAL_VELOCITY, 32'h8000_0000);
    write_reg(REG_INITIAL_ACCEL, 32'h7FFF_FFFF);
    write_reg(REG_R_MEASURE, 32'h8000_0001);
    send_word(32'sh0000_0000, 16'h0100);
    send_word(32'sh1234_5678, 16'h0200);
    drain();
  endtask

  // Random words under several register settings, with pressure episodes.
  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_Q_VELOCITY, 32'd3277);
          write_reg(REG_Q_ACCEL, 32'd3277);
          write_reg(REG_R_MEASURE, 32'd13107);
        end
        5: begin
          write_reg(REG_Q_VELOCITY, 32'd0);
          write_reg(REG_Q_ACCEL, 32'd1);
          write_reg(REG_R_MEASURE, 32'd1);
        end
        default: begin
          write_reg(REG_Q_VELOCITY, $urandom_range(65536 * 2));
          write_reg(REG_Q_ACCEL, $urandom_range(65536));
          write_reg(REG_R_MEASURE, ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536 * 4));
        end
      endcase
      write_reg(REG_INITIAL_VELOCITY, $signed($urandom_range(65536 * 20)) - 65536 * 10);
      write_reg(REG_INITIAL_ACCEL, ($urandom_range(4) == 0) ? $urandom : 32'h0);
      for (int n = 0; n < 250; n++) begin
        if (phase == 1 && n == 40) hold_request = 400;
        if (phase == 2 && n == 100) quiet = 1'b1;
        if (phase == 2 && n == 180) quiet = 1'b0;
        if (phase == 3 && n == 120) drain();
        send_word(rand_meas(), rand_step());
      end
      drain();
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_Q_VELOCITY;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    measured_velocity_i = '0;
    time_step_i         = '0;
    out_stall_i         = 1'b0;
    fail_count          = 0;
    quiet               = 1'b0;
    hold_request        = 0;
    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);

    test_field_extremes();
    test_zero_innovation();
    test_registers();
    test_random();

    if (fail_count == 0) begin
      $display("velocity_accel_kalman_filter_top regression: pass");
    end else begin
      $display("velocity_accel_kalman_filter_top regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/vakf_pkg.sv
design/vakf_div.sv
design/vakf_datapath.sv
design/vakf_ctrl.sv
design/velocity_accel_kalman_filter_top.sv
design/vakf_checker.sv
bench/velocity_accel_kalman_filter_top_test.sv
